// ===== hdl/pulse_peak_counter_top_assert.svh =====
// Assertion macros for the pulse peak counter top level.
// Expects clk_i and rst_ni in the scope of use.
`ifndef PULSE_PEAK_COUNTER_TOP_ASSERT_SVH
`define PULSE_PEAK_COUNTER_TOP_ASSERT_SVH

// same-cycle implication
`define PPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pulse_peak_counter: same-cycle check failed");

// next-cycle implication
`define PPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pulse_peak_counter: next-cycle check failed");

`endif

// ===== hdl/ppc_pkg.sv =====
// Shared constants, types and codes of the pulse peak counter.
// No dependencies.
package ppc_pkg;

  localparam int SAMPLE_BITS        = 16;
  localparam int MAX_PERIOD_SAMPLES = 128;
  localparam int SUM_W              = 23;
  localparam int IDX_W              = 8;
  localparam int DIV_STEPS          = SUM_W;
  localparam int STEP_W             = $clog2(DIV_STEPS);
  localparam int ADDR_W             = 5;

  localparam logic [SUM_W-1:0]  SUM_MAX      = '1;
  localparam logic [8:0]        WEIGHT_FULL  = 9'd256;
  localparam logic [24:0]       ROUND_HALF   = 25'd128;
  localparam logic signed [21:0] OFFSET_TENTH = 22'sd6554;
  localparam logic signed [21:0] NORM_LO     = -22'sd1048576;
  localparam logic signed [21:0] NORM_HI     = 22'sd1048575;
  localparam logic [IDX_W-1:0]  LEN_MIN      = 8'd2;
  localparam logic [IDX_W-1:0]  LEN_MAX      = IDX_W'(MAX_PERIOD_SAMPLES);
  localparam logic [7:0]        SPACE_SAT    = 8'hFF;
  localparam logic [7:0]        BEATS_SAT    = 8'hFF;

  // register reset values
  localparam logic [8:0]  RST_WEIGHT  = 9'd128;
  localparam logic [19:0] RST_THRESH  = 20'd19661;
  localparam logic [7:0]  RST_SPACING = 8'd10;
  localparam logic [7:0]  RST_PERIOD  = 8'd80;
  localparam logic [3:0]  RST_WINDOW  = 4'd15;

  typedef enum logic [2:0] {
    REG_WEIGHT  = 3'd0,
    REG_THRESH  = 3'd1,
    REG_SPACING = 3'd2,
    REG_PERIOD  = 3'd3,
    REG_WINDOW  = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILTER,
    ST_ACCUM,
    ST_DIVIDE,
    ST_NORM,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic [8:0]  weight;
    logic [19:0] thresh;
    logic [7:0]  spacing;
    logic [7:0]  period;
    logic [3:0]  window;
  } cfg_t;

  typedef struct packed {
    logic seed;
    logic load;
    logic filter;
    logic accum;
    logic div_step;
    logic norm;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic seeded;
    logic out_busy;
  } status_t;

endpackage

// ===== hdl/ppc_regs.sv =====
// APB configuration registers of the pulse peak counter.
// Depends on ppc_pkg.
module ppc_regs import ppc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weight  <= RST_WEIGHT;
      cfg_q.thresh  <= RST_THRESH;
      cfg_q.spacing <= RST_SPACING;
      cfg_q.period  <= RST_PERIOD;
      cfg_q.window  <= RST_WINDOW;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_WEIGHT:  cfg_q.weight  <= pwdata[8:0];
        REG_THRESH:  cfg_q.thresh  <= pwdata[19:0];
        REG_SPACING: cfg_q.spacing <= pwdata[7:0];
        REG_PERIOD:  cfg_q.period  <= pwdata[7:0];
        REG_WINDOW:  cfg_q.window  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_WEIGHT:  prdata = 32'(cfg_q.weight);
      REG_THRESH:  prdata = 32'(cfg_q.thresh);
      REG_SPACING: prdata = 32'(cfg_q.spacing);
      REG_PERIOD:  prdata = 32'(cfg_q.period);
      REG_WINDOW:  prdata = 32'(cfg_q.window);
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== hdl/ppc_ctrl.sv =====
// Sequencing state machine of the pulse peak counter.
// Depends on ppc_pkg; drives the datapath through cmd_t.
module ppc_ctrl import ppc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic accept;

  // ready is high exactly in idle, so take it from the state register
  assign accept = in_valid_i & (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && status_i.seeded) state_d = ST_FILTER;
      end
      ST_FILTER: state_d = ST_ACCUM;
      ST_ACCUM: begin
        state_d = ST_DIVIDE;
        step_d  = '0;
      end
      ST_DIVIDE: begin
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_NORM;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_NORM: state_d = ST_FINISH;
      ST_FINISH: begin
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.seed  = accept & ~status_i.seeded;
        cmd_o.load  = accept & status_i.seeded;
      end
      ST_FILTER: cmd_o.filter   = 1'b1;
      ST_ACCUM:  cmd_o.accum    = 1'b1;
      ST_DIVIDE: cmd_o.div_step = 1'b1;
      ST_NORM:   cmd_o.norm     = 1'b1;
      ST_FINISH: cmd_o.finish   = ~status_i.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== hdl/ppc_datapath.sv =====
// Datapath of the pulse peak counter: filter, running sum, serial divider,
// beat test, counters and the output register. Depends on ppc_pkg.
module ppc_datapath import ppc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic [15:0]         sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [20:0]  norm_value_o,
  output logic                beat_o,
  output logic [7:0]          beat_count_o,
  output logic                period_done_o,
  output logic                window_done_o
);

  logic              seeded_q;
  logic [15:0]       x_q;
  logic [15:0]       smooth_q, smooth_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SUM_W-1:0]  quo_q;
  logic [IDX_W-1:0]  rem_q;
  logic signed [20:0] norm_q, norm_d;
  logic [3:0]        period_q;
  logic [7:0]        beats_q;
  logic [7:0]        since_q;
  logic              out_valid_q;

  logic [15:0]       x_in;
  logic [8:0]        w_eff, w_rest;
  logic [24:0]       filt_acc;
  logic [SUM_W:0]    sum_wide;
  logic [IDX_W:0]    trial;
  logic              trial_ge;
  logic [15:0]       mean;
  logic signed [21:0] diff, norm_wide;
  logic [7:0]        since_inc, beats_inc;
  logic              beat;
  logic [IDX_W-1:0]  len;
  logic              pdone, wdone;
  logic [3:0]        period_inc, win;

  assign x_in = 16'(sample_i[SAMPLE_BITS-1:0]) << (16 - SAMPLE_BITS);

  // exponential filter, rounds half up
  assign w_eff    = (cfg_i.weight > WEIGHT_FULL) ? WEIGHT_FULL : cfg_i.weight;
  assign w_rest   = WEIGHT_FULL - w_eff;
  assign filt_acc = 25'(w_eff) * 25'(x_q) + 25'(w_rest) * 25'(smooth_q) + ROUND_HALF;
  assign smooth_d = filt_acc[23:8];

  assign sum_wide = {1'b0, sum_q} + (SUM_W+1)'(smooth_q);
  assign sum_d    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign idx_d    = (idx_q == '1) ? IDX_W'(1) : idx_q + 1'b1;

  // restoring divide, one quotient bit per step
  assign trial    = {rem_q, quo_q[SUM_W-1]};
  assign trial_ge = trial >= {1'b0, idx_q};

  assign mean      = (|quo_q[SUM_W-1:16]) ? 16'hFFFF : quo_q[15:0];
  assign diff      = $signed({6'b0, smooth_q}) - $signed({6'b0, mean});
  assign norm_wide = (diff <<< 2) + OFFSET_TENTH;
  always_comb begin
    if (norm_wide < NORM_LO)      norm_d = NORM_LO[20:0];
    else if (norm_wide > NORM_HI) norm_d = NORM_HI[20:0];
    else                          norm_d = norm_wide[20:0];
  end

  // beat test and period bookkeeping
  assign since_inc  = (since_q == SPACE_SAT) ? SPACE_SAT : since_q + 1'b1;
  assign beat       = ($signed(norm_q) >= $signed({1'b0, cfg_i.thresh}))
                      && (since_inc >= cfg_i.spacing);
  assign beats_inc  = (beat && beats_q != BEATS_SAT) ? beats_q + 1'b1 : beats_q;
  assign len        = (cfg_i.period < LEN_MIN) ? LEN_MIN :
                      (cfg_i.period > LEN_MAX) ? LEN_MAX : cfg_i.period;
  assign pdone      = idx_q >= len;
  assign period_inc = period_q + 1'b1;
  assign win        = (cfg_i.window == '0) ? 4'd1 : cfg_i.window;
  assign wdone      = pdone && (period_inc >= win);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q    <= 1'b0;
      smooth_q    <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      period_q    <= '0;
      beats_q     <= '0;
      since_q     <= SPACE_SAT;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.seed) begin
        seeded_q <= 1'b1;
        smooth_q <= x_in;
      end
      if (cmd_i.filter) smooth_q <= smooth_d;
      if (cmd_i.accum) begin
        sum_q <= sum_d;
        idx_q <= idx_d;
      end
      if (cmd_i.finish) begin
        since_q <= beat ? '0 : since_inc;
        beats_q <= wdone ? '0 : beats_inc;
        if (pdone) begin
          sum_q    <= quo_q;
          idx_q    <= IDX_W'(1);
          period_q <= wdone ? '0 : period_inc;
        end
      end
      if (cmd_i.finish)     out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) x_q <= x_in;
    if (cmd_i.accum) begin
      quo_q <= sum_d;
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], trial_ge};
      rem_q <= trial_ge ? IDX_W'(trial - {1'b0, idx_q}) : trial[IDX_W-1:0];
    end
    if (cmd_i.norm) norm_q <= norm_d;
    if (cmd_i.finish) begin
      norm_value_o  <= norm_q;
      beat_o        <= beat;
      beat_count_o  <= beats_inc;
      period_done_o <= pdone;
      window_done_o <= wdone;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o.seeded   = seeded_q;
  assign status_o.out_busy = out_valid_q & ~out_ready_i;

endmodule

// ===== hdl/pulse_peak_counter_top.sv =====
// Top level of the pulse peak counter: APB registers, controller, datapath.
// Depends on ppc_pkg, ppc_regs, ppc_ctrl, ppc_datapath and the assertion header.

// Pulse peak counter. Each accepted sample goes through the exponential filter, is added to
// the running sum, and the sum is divided by the sample index in a restoring divider that
// yields one quotient bit per cycle; the detrended value, beat test and counters follow. No
// new sample is taken while one is in work: the next is accepted only after the result is
// committed, and the commit waits while an earlier result in the output register is untaken.
// The first sample after reset only seeds the filter, gives no result and is followed by the
// next acceptance in the very next cycle. A finished result sits in an output register, so the
// next sample is accepted while it waits to be taken. Registers: weight at 0x00, threshold
// 0x04, minimum spacing 0x08, samples per period 0x0C, periods per window 0x10.
module pulse_peak_counter_top import ppc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [20:0] norm_value_o,
  output logic               beat_o,
  output logic [7:0]         beat_count_o,
  output logic               period_done_o,
  output logic               window_done_o
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  ppc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ppc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .status_o      (status),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .norm_value_o  (norm_value_o),
    .beat_o        (beat_o),
    .beat_count_o  (beat_count_o),
    .period_done_o (period_done_o),
    .window_done_o (window_done_o)
  );

`include "pulse_peak_counter_top_assert.svh"

  `PPC_ASSERT_NOW(a_window_ends_period, out_valid_o && window_done_o, period_done_o)
  `PPC_ASSERT_NOW(a_beat_counted, out_valid_o && beat_o, beat_count_o != 8'd0)
  `PPC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o && status.seeded, !in_ready_o)
  `PPC_ASSERT_NOW(a_result_from_commit, $rose(out_valid_o), $past(cmd.finish))

endmodule
